FILE: rtl/core/phfst_pkg.sv
package phfst_pkg;

  localparam int unsigned RamAw = 8;
  localparam int unsigned RamDepth = 256;

  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_PIN   = 2'd2
  } action_e;

  // i/o register select, address bits 2..0
  localparam logic [2:0] IoHead   = 3'd1;
  localparam logic [2:0] IoFeed   = 3'd2;
  localparam logic [2:0] IoStatus = 3'd3;

  localparam logic [7:0]  Unmapped    = 8'hFF;
  localparam logic [6:0]  StatusHigh  = 7'h7F;
  localparam logic [7:0]  PinReset    = 8'hFF;
  localparam logic [12:0] PeriodHold  = 13'd4060;
  localparam logic [12:0] PeriodOdd   = 13'd4700;
  localparam logic [12:0] PeriodEven  = 13'd2040;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] address;
    logic [7:0]  data;
    logic [31:0] tick;
  } in_item_t;

  typedef struct packed {
    logic [7:0]        read_data;
    logic [9:0]        head_position;
    logic              feed_advanced;
    logic [6:0]        pins_fired;
    logic [2:0]        pins_count;
    logic [31:0]       time_since_step;
    logic [12:0]       step_period;
    logic signed [2:0] step_distance;
  } out_item_t;

  typedef struct packed {
    logic       ok;
    logic [2:0] ph;
  } head_phase_t;

  typedef struct packed {
    logic       ok;
    logic [1:0] ph;
  } feed_phase_t;

  function automatic head_phase_t head_phase(input logic [3:0] nib);
    head_phase_t r;
    r = '{ok: 1'b1, ph: 3'd0};
    case (nib)
      4'd3:  r.ph = 3'd4;
      4'd6:  r.ph = 3'd2;
      4'd7:  r.ph = 3'd3;
      4'd9:  r.ph = 3'd6;
      4'd11: r.ph = 3'd5;
      4'd12: r.ph = 3'd0;
      4'd13: r.ph = 3'd7;
      4'd14: r.ph = 3'd1;
      default: r.ok = 1'b0;
    endcase
    return r;
  endfunction

  function automatic feed_phase_t feed_phase(input logic [3:0] nib);
    feed_phase_t r;
    r = '{ok: 1'b1, ph: 2'd0};
    case (nib)
      4'd3:  r.ph = 2'd2;
      4'd6:  r.ph = 2'd1;
      4'd9:  r.ph = 2'd3;
      4'd12: r.ph = 2'd0;
      default: r.ok = 1'b0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/core/phfst_in_if.sv
interface phfst_in_if;
  import phfst_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/core/phfst_out_if.sv
interface phfst_out_if;
  import phfst_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/core/printer_head_and_feed_stepper_tracker_unit.sv
// channel | dir | contents
// in_i    | in  | action, address, data, tick (bus read, bus write, pin port write)
// out_o   | out | read data, head position, feed step, fired pins, step timing
//
// one item per cycle sustained while the output is not stalled; a result passes the input and output registers
// the ram read port is clocked when the item is taken, all state moves once per item
// when the item passes from the input register into the output register
// reset clears head and feed latches and state and step timing, sets pin latch to ones; ram content is undefined
// a stalled output holds its register, the input register then fills and ready drops
module printer_head_and_feed_stepper_tracker_unit #(
  parameter int unsigned HEAD_POS_MAX = 1023
) (
  input  logic clk_i,
  input  logic rst_ni,
  phfst_in_if.sink    in_i,
  phfst_out_if.source out_o
);
  import phfst_pkg::*;

  localparam int unsigned PosW = $clog2(HEAD_POS_MAX + 1);
  localparam logic [PosW:0] PosMaxW = (PosW + 1)'(HEAD_POS_MAX);
  localparam logic [PosW-1:0] PosMax = PosMaxW[PosW-1:0];

  // handshake
  logic in_ready, accept, out_adv, commit;
  logic s1_valid_q, out_valid_q;
  in_item_t  s1_q;
  out_item_t out_q, out_d;

  assign out_adv  = !out_valid_q || out_o.ready;
  assign commit   = s1_valid_q && out_adv;
  assign in_ready = !s1_valid_q || out_adv;
  assign accept   = in_i.valid && in_ready;

  assign in_i.ready    = in_ready;
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (commit) begin
        s1_valid_q <= 1'b0;
      end
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= in_i.payload;
    end
    if (commit) begin
      out_q <= out_d;
    end
  end

  // scratch ram
  logic [7:0]       ram [RamDepth];
  logic [7:0]       ram_rd_q;
  logic             ram_we;
  logic [RamAw-1:0] ram_wa;

  assign ram_wa = s1_q.address[RamAw-1:0];

  // the item in the input register writes at the same edge the next one reads
  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      ram[ram_wa] <= s1_q.data;
    end
    if (accept) begin
      if (ram_we && ram_wa == in_i.payload.address[RamAw-1:0]) begin
        ram_rd_q <= s1_q.data;
      end else begin
        ram_rd_q <= ram[in_i.payload.address[RamAw-1:0]];
      end
    end
  end

  // tracker state
  logic [7:0]        head_latch_q, head_latch_d;
  logic [7:0]        feed_latch_q, feed_latch_d;
  logic [7:0]        pin_latch_q, pin_latch_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic [1:0]        feed_ph_q, feed_ph_d;
  logic [31:0]       step_tick_q, step_tick_d;
  logic [12:0]       period_q, period_d;
  logic signed [2:0] dist_q, dist_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_latch_q <= '0;
      feed_latch_q <= '0;
      pin_latch_q  <= PinReset;
      pos_q        <= '0;
      feed_ph_q    <= '0;
      step_tick_q  <= '0;
      period_q     <= '0;
      dist_q       <= '0;
    end else if (commit) begin
      head_latch_q <= head_latch_d;
      feed_latch_q <= feed_latch_d;
      pin_latch_q  <= pin_latch_d;
      pos_q        <= pos_d;
      feed_ph_q    <= feed_ph_d;
      step_tick_q  <= step_tick_d;
      period_q     <= period_d;
      dist_q       <= dist_d;
    end
  end

  // head moves, computed from the current position
  logic [PosW:0]   up2_sum;
  logic [PosW-1:0] pos_up1, pos_up2, pos_dn1, pos_dn2;

  always_comb begin
    up2_sum = {1'b0, pos_q} + (PosW + 1)'(2);
    pos_up1 = (pos_q < PosMax) ? pos_q + PosW'(1) : pos_q;
    pos_up2 = (up2_sum > PosMaxW) ? PosMax : up2_sum[PosW-1:0];
    pos_dn1 = (pos_q != '0) ? pos_q - PosW'(1) : pos_q;
    pos_dn2 = (pos_q >= PosW'(2)) ? pos_q - PosW'(2) : '0;
  end

  head_phase_t hp;
  feed_phase_t fp;
  logic [2:0]  hd;
  logic [1:0]  fd;
  logic [7:0]  rd;
  logic        fed;
  logic [7:0]  pin_delta;
  logic [6:0]  pins;

  always_comb begin
    head_latch_d = head_latch_q;
    feed_latch_d = feed_latch_q;
    pin_latch_d  = pin_latch_q;
    pos_d        = pos_q;
    feed_ph_d    = feed_ph_q;
    step_tick_d  = step_tick_q;
    period_d     = period_q;
    dist_d       = dist_q;
    ram_we       = 1'b0;
    rd           = '0;
    fed          = 1'b0;
    pins         = '0;
    hp           = head_phase(s1_q.data[7:4]);
    fp           = feed_phase(s1_q.data[7:4]);
    hd           = hp.ph - pos_q[2:0];
    fd           = fp.ph - feed_ph_q;
    pin_delta    = pin_latch_q ^ s1_q.data;

    case (s1_q.action)
      ACT_READ: begin
        if (s1_q.address[15]) begin
          rd = Unmapped;
        end else if (!s1_q.address[14]) begin
          rd = ram_rd_q;
        end else begin
          case (s1_q.address[2:0])
            IoHead:   rd = head_latch_q;
            IoFeed:   rd = feed_latch_q;
            IoStatus: rd = {StatusHigh, pos_q == '0};
            default:  rd = Unmapped;
          endcase
        end
      end
      ACT_WRITE: begin
        if (!s1_q.address[15]) begin
          if (!s1_q.address[14]) begin
            ram_we = commit;
          end else if (s1_q.address[2:0] == IoHead) begin
            if (s1_q.data != head_latch_q) begin
              head_latch_d = s1_q.data;
              if (!s1_q.data[0] && hp.ok) begin
                case (hd)
                  3'd1:    pos_d = pos_up1;
                  3'd2:    pos_d = pos_up2;
                  3'd6:    pos_d = pos_dn2;
                  3'd7:    pos_d = pos_dn1;
                  default: pos_d = pos_q;
                endcase
                step_tick_d = s1_q.tick;
                // single steps take longer leaving an odd half step
                if (hd == 3'd1 || hd == 3'd7) begin
                  period_d = pos_d[0] ? PeriodOdd : PeriodEven;
                end else begin
                  period_d = PeriodHold;
                end
                case (hd)
                  3'd1:    dist_d = 3'sd1;
                  3'd2:    dist_d = 3'sd2;
                  3'd6:    dist_d = -3'sd2;
                  3'd7:    dist_d = -3'sd1;
                  default: dist_d = 3'sd0;
                endcase
              end
            end
          end else if (s1_q.address[2:0] == IoFeed) begin
            if (s1_q.data != feed_latch_q) begin
              feed_latch_d = s1_q.data;
              if (!s1_q.data[0] && fp.ok) begin
                if (fd == 2'd3) begin
                  feed_ph_d = feed_ph_q - 2'd1;
                end else if (fd == 2'd1) begin
                  feed_ph_d = feed_ph_q + 2'd1;
                  fed       = 1'b1;
                end
              end
            end
          end
        end
      end
      ACT_PIN: begin
        if (s1_q.address[0] && pin_delta != '0) begin
          pin_latch_d = s1_q.data;
          pins        = pin_delta[6:0] & ~s1_q.data[6:0];
        end
      end
      default: ;
    endcase

    out_d.read_data       = rd;
    out_d.head_position   = 10'(pos_d);
    out_d.feed_advanced   = fed;
    out_d.pins_fired      = pins;
    out_d.pins_count      = 3'($countones(pins));
    out_d.time_since_step = s1_q.tick - step_tick_d;
    out_d.step_period     = period_d;
    out_d.step_distance   = dist_d;
  end

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosMax)
    else $error("head position beyond its limit");

  a_pos_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> ({1'b0, pos_q} <= {1'b0, $past(pos_q)} + (PosW + 1)'(2)) &&
             ({1'b0, $past(pos_q)} <= {1'b0, pos_q} + (PosW + 1)'(2)))
    else $error("head moved more than two half steps for one item");

  a_period_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    period_q == '0 || period_q == PeriodHold || period_q == PeriodOdd ||
    period_q == PeriodEven)
    else $error("step period holds an unknown value");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !commit |=> $stable(pos_q) && $stable(step_tick_q) && $stable(pin_latch_q))
    else $error("tracker state moved without an item");

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import phfst_pkg::*;

  localparam int unsigned HeadTop       = 1023;
  localparam int unsigned HoldOffCycles = 300;
  // unused action code, the block must ignore it
  localparam logic [1:0]  ActSpare      = 2'd3;

  typedef enum int {SegMixed, SegRise, SegFall} seg_e;

  typedef struct {
    in_item_t  stim;
    bit        known;
    out_item_t want;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  phfst_in_if  in_if ();
  phfst_out_if out_if ();

  printer_head_and_feed_stepper_tracker_unit #(
    .HEAD_POS_MAX(HeadTop)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #2 clk_i = ~clk_i;

  // phase decode and its inverse, for prediction and for building step sequences
  int         head_ph_of [16] = '{-1, -1, -1, 4, -1, -1, 2, 3, -1, 6, -1, 5, 0, 7, 1, -1};
  int         feed_ph_of [16] = '{-1, -1, -1, 2, -1, -1, 1, -1, -1, 3, -1, -1, 0, -1, -1, -1};
  logic [3:0] head_nib_of [8] = '{4'd12, 4'd14, 4'd6, 4'd7, 4'd3, 4'd11, 4'd9, 4'd13};
  logic [3:0] feed_nib_of [4] = '{4'd12, 4'd6, 4'd3, 4'd9};

  // tracked chip state
  logic [7:0]        trk_ram [256];
  bit                trk_ram_ok [256];
  logic [7:0]        ram_known_q [$];
  logic [7:0]        trk_head_latch  = 8'h00;
  logic [7:0]        trk_feed_latch  = 8'h00;
  logic [7:0]        trk_pin_latch   = PinReset;
  logic [9:0]        trk_head_pos    = '0;
  logic [1:0]        trk_feed_ph     = '0;
  logic [31:0]       trk_step_tick   = '0;
  logic [12:0]       trk_step_period = '0;
  logic signed [2:0] trk_step_dist   = '0;

  out_item_t  due_reports [$];
  dir_row_t   dir_rows [$];
  out_item_t  got_rpt;
  out_item_t  want_rpt;
  int         mismatches   = 0;
  logic [31:0] step_clock  = 32'd9000;
  bit         sender_eager = 1'b0;
  bit         hold_off_req = 1'b0;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic out_item_t track_item(input in_item_t it);
    out_item_t  res;
    logic [7:0] delta;
    logic [2:0] hdist;
    logic [1:0] fdist;
    int         steps;
    res = '0;
    case (it.action)
      ACT_READ: begin
        if (it.address[15]) begin
          res.read_data = Unmapped;
        end else if (!it.address[14]) begin
          res.read_data = trk_ram[it.address[7:0]];
        end else begin
          case (it.address[2:0])
            IoHead:   res.read_data = trk_head_latch;
            IoFeed:   res.read_data = trk_feed_latch;
            IoStatus: res.read_data = {StatusHigh, trk_head_pos == '0};
            default:  res.read_data = Unmapped;
          endcase
        end
      end
      ACT_WRITE: begin
        if (!it.address[15] && !it.address[14]) begin
          if (!trk_ram_ok[it.address[7:0]]) ram_known_q.push_back(it.address[7:0]);
          trk_ram[it.address[7:0]] = it.data;
          trk_ram_ok[it.address[7:0]] = 1'b1;
        end else if (!it.address[15] && it.address[2:0] == IoHead &&
                     trk_head_latch != it.data) begin
          trk_head_latch = it.data;
          if (!it.data[0] && head_ph_of[it.data[7:4]] >= 0) begin
            hdist = 3'(head_ph_of[it.data[7:4]]) - trk_head_pos[2:0];
            case (hdist)
              3'd1:    steps = 1;
              3'd2:    steps = 2;
              3'd6:    steps = -2;
              3'd7:    steps = -1;
              default: steps = 0;
            endcase
            if (steps > 0) begin
              repeat (steps)
                if (trk_head_pos < 10'(HeadTop)) trk_head_pos = trk_head_pos + 10'd1;
            end else begin
              repeat (-steps) if (trk_head_pos != '0) trk_head_pos = trk_head_pos - 10'd1;
            end
            // a step is stamped even when clipped or too far away to move
            trk_step_tick = it.tick;
            if (steps == 1 || steps == -1) begin
              trk_step_period = trk_head_pos[0] ? PeriodOdd : PeriodEven;
            end else begin
              trk_step_period = PeriodHold;
            end
            trk_step_dist = 3'(steps);
          end
        end else if (!it.address[15] && it.address[2:0] == IoFeed &&
                     trk_feed_latch != it.data) begin
          trk_feed_latch = it.data;
          if (!it.data[0] && feed_ph_of[it.data[7:4]] >= 0) begin
            fdist = 2'(feed_ph_of[it.data[7:4]]) - trk_feed_ph;
            if (fdist == 2'd3) begin
              trk_feed_ph = trk_feed_ph - 2'd1;
            end else if (fdist == 2'd1) begin
              trk_feed_ph = trk_feed_ph + 2'd1;
              res.feed_advanced = 1'b1;
            end
          end
        end
      end
      ACT_PIN: begin
        if (it.address[0]) begin
          delta = trk_pin_latch ^ it.data;
          if (delta != '0) begin
            trk_pin_latch = it.data;
            res.pins_fired = delta[6:0] & ~it.data[6:0];
            res.pins_count = 3'($countones(res.pins_fired));
          end
        end
      end
      default: ;
    endcase
    res.head_position   = trk_head_pos;
    res.time_since_step = it.tick - trk_step_tick;
    res.step_period     = trk_step_period;
    res.step_distance   = trk_step_dist;
    return res;
  endfunction

  function automatic in_item_t make_item(input seg_e seg);
    in_item_t    it;
    int unsigned pick;
    int unsigned k;
    logic [2:0]  hph;
    logic [1:0]  fph;
    it.action  = ACT_WRITE;
    it.address = 16'($urandom);
    it.data    = 8'($urandom);
    if ($urandom_range(0, 19) == 0) step_clock = $urandom;
    else step_clock = step_clock + $urandom_range(0, 6000);
    it.tick = step_clock;
    // sweeps are mostly head steps in one direction
    pick = (seg != SegMixed && $urandom_range(0, 9) != 0) ? 40 : $urandom_range(0, 99);
    if (pick >= 18 && pick < 32 && ram_known_q.size() == 0) pick = 0;
    if (pick < 18) begin
      it.address[15:14] = 2'b00;
    end else if (pick < 32) begin
      it.action  = ACT_READ;
      it.address = {2'b00, 6'($urandom), ram_known_q[$urandom_range(0, ram_known_q.size() - 1)]};
    end else if (pick < 57) begin
      case (seg)
        SegRise: k = ($urandom_range(0, 19) != 0) ? 2 : 1;
        SegFall: k = ($urandom_range(0, 19) != 0) ? 6 : 7;
        default: begin
          k = $urandom_range(0, 3);
          k = ($urandom_range(0, 9) < 7) ? ((k < 2) ? k + 1 : k + 4) : $urandom_range(0, 7);
        end
      endcase
      hph = trk_head_pos[2:0] + 3'(k);
      it.address = {2'b01, 11'($urandom), IoHead};
      it.data    = {head_nib_of[hph], 3'($urandom), 1'b0};
      if (seg == SegMixed && $urandom_range(0, 9) == 0) it.data = 8'($urandom);
    end else if (pick < 70) begin
      k = ($urandom_range(0, 9) < 7) ? 1 : $urandom_range(0, 3);
      fph = trk_feed_ph + 2'(k);
      it.address = {2'b01, 11'($urandom), IoFeed};
      it.data    = {feed_nib_of[fph], 3'($urandom), 1'b0};
      if ($urandom_range(0, 9) == 0) it.data = 8'($urandom);
    end else if (pick < 82) begin
      it.action     = ACT_PIN;
      it.address[0] = ($urandom_range(0, 9) != 0);
      if ($urandom_range(0, 1) == 0) it.data = trk_pin_latch ^ (8'h01 << $urandom_range(0, 7));
    end else if (pick < 92) begin
      it.action = ACT_READ;
      it.address[15:14] = ($urandom_range(0, 9) < 7) ? 2'b01 : {1'b1, 1'($urandom)};
    end else begin
      it.action = 2'($urandom);
      // never read scratch ram that holds nothing yet
      if (it.action == ACT_READ && it.address[15:14] == 2'b00 && !trk_ram_ok[it.address[7:0]])
        it.action = ACT_WRITE;
    end
    return it;
  endfunction

  // typed rows all lie before the first head step: position, period and distance are zero
  function automatic void add_row(input bit kn, input logic [1:0] act, input logic [15:0] adr,
                                  input logic [7:0] dat, input logic [31:0] tck,
                                  input logic [7:0] rd, input logic [6:0] pins,
                                  input logic [2:0] cnt, input logic [31:0] since);
    dir_row_t r;
    r.stim.action  = act;
    r.stim.address = adr;
    r.stim.data    = dat;
    r.stim.tick    = tck;
    r.known        = kn;
    r.want                 = '0;
    r.want.read_data       = rd;
    r.want.pins_fired      = pins;
    r.want.pins_count      = cnt;
    r.want.time_since_step = since;
    dir_rows.push_back(r);
  endfunction

  task automatic offer_item(input in_item_t it, input bit known, input out_item_t want);
    out_item_t   calc;
    int unsigned gap;
    in_if.payload <= it;
    in_if.valid   <= 1'b1;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    calc = track_item(it);
    due_reports.push_back(known ? want : calc);
    @(negedge clk_i);
    gap = sender_eager ? 0 : pick_gap();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic run_segment(input seg_e seg, input int unsigned count);
    int unsigned n;
    n = 0;
    while ((n < count || (seg == SegRise && trk_head_pos != 10'(HeadTop)) ||
            (seg == SegFall && trk_head_pos != '0)) && n < 1500) begin
      offer_item(make_item(seg), 1'b0, '0);
      n++;
    end
  endtask

  task automatic report_mismatch(input string msg);
    if (mismatches < 100) $display("%0t ns: mismatch, %s", $time, msg);
    mismatches++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (due_reports.size() == 0) begin
        report_mismatch("report item with nothing due");
      end else begin
        want_rpt = due_reports.pop_front();
        got_rpt  = out_if.payload;
        compare_field("read_data", 32'(got_rpt.read_data), 32'(want_rpt.read_data));
        compare_field("head_position", 32'(got_rpt.head_position),
                      32'(want_rpt.head_position));
        compare_field("feed_advanced", 32'(got_rpt.feed_advanced),
                      32'(want_rpt.feed_advanced));
        compare_field("pins_fired", 32'(got_rpt.pins_fired), 32'(want_rpt.pins_fired));
        compare_field("pins_count", 32'(got_rpt.pins_count), 32'(want_rpt.pins_count));
        compare_field("time_since_step", got_rpt.time_since_step, want_rpt.time_since_step);
        compare_field("step_period", 32'(got_rpt.step_period), 32'(want_rpt.step_period));
        compare_field("step_distance", 32'(got_rpt.step_distance),
                      32'(want_rpt.step_distance));
      end
    end
  end

  // receiver throttle, with one long hold-off on request
  initial begin
    int unsigned burst;
    int unsigned gap;
    out_if.ready = 1'b0;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HoldOffCycles) @(negedge clk_i);
      end
      burst = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 20);
      out_if.ready <= 1'b1;
      repeat (burst) @(negedge clk_i);
      gap = pick_gap();
      if (gap != 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
  end

  initial begin
    #4_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    in_if.valid   = 1'b0;
    in_if.payload = '0;

    //      kn  act        addr      data   tick           rd     pins   cnt   since
    add_row(1, ACT_READ,  16'h4003, 8'h00, 32'd100,       8'hFF, 7'h00, 3'd0, 32'd100);
    add_row(1, ACT_READ,  16'hFFFF, 8'h00, 32'hFFFF_FFFF, 8'hFF, 7'h00, 3'd0, 32'hFFFF_FFFF);
    add_row(1, ACT_READ,  16'h4001, 8'h00, 32'd7,         8'h00, 7'h00, 3'd0, 32'd7);
    add_row(1, ACT_READ,  16'h7FFA, 8'h00, 32'd8,         8'h00, 7'h00, 3'd0, 32'd8);
    add_row(1, ACT_READ,  16'h4004, 8'h00, 32'd9,         8'hFF, 7'h00, 3'd0, 32'd9);
    add_row(1, ACT_WRITE, 16'h0000, 8'h00, 32'd10,        8'h00, 7'h00, 3'd0, 32'd10);
    add_row(1, ACT_WRITE, 16'h3FFF, 8'hFF, 32'd11,        8'h00, 7'h00, 3'd0, 32'd11);
    add_row(0, ACT_READ,  16'h00FF, 8'h00, 32'd12,        '0, '0, '0, '0);
    add_row(1, ACT_PIN,   16'h0001, 8'h00, 32'd14,        8'h00, 7'h7F, 3'd7, 32'd14);
    add_row(1, ACT_PIN,   16'hFFFE, 8'hFF, 32'd15,        8'h00, 7'h00, 3'd0, 32'd15);
    add_row(0, ACT_PIN,   16'h0001, 8'hD5, 32'd16,        '0, '0, '0, '0);
    add_row(0, ACT_PIN,   16'h0001, 8'h80, 32'd17,        '0, '0, '0, '0);
    add_row(0, ACT_WRITE, 16'h4001, 8'hE0, 32'd1000,      '0, '0, '0, '0);
    add_row(0, ACT_WRITE, 16'h4001, 8'h60, 32'd3000,      '0, '0, '0, '0);
    add_row(0, ACT_READ,  16'h4003, 8'h00, 32'd3100,      '0, '0, '0, '0);
    add_row(0, ACT_WRITE, 16'h4001, 8'hB0, 32'd5000,      '0, '0, '0, '0);
    add_row(0, ACT_WRITE, 16'h4001, 8'hB1, 32'd5100,      '0, '0, '0, '0);
    add_row(0, ACT_WRITE, 16'h4001, 8'h10, 32'd5200,      '0, '0, '0, '0);
    add_row(0, ACT_WRITE, 16'h4001, 8'hC0, 32'd6000,      '0, '0, '0, '0);
    add_row(0, ACT_WRITE, 16'h4001, 8'hD0, 32'd8000,      '0, '0, '0, '0);
    add_row(0, ACT_WRITE, 16'h4002, 8'h60, 32'd8100,      '0, '0, '0, '0);
    add_row(0, ACT_WRITE, 16'h4002, 8'h90, 32'd8200,      '0, '0, '0, '0);
    add_row(0, ACT_WRITE, 16'h4002, 8'hC0, 32'd8300,      '0, '0, '0, '0);
    add_row(0, ACT_WRITE, 16'hC001, 8'hE0, 32'd8400,      '0, '0, '0, '0);
    add_row(0, ActSpare,  16'h4001, 8'h60, 32'd8500,      '0, '0, '0, '0);

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) offer_item(dir_rows[i].stim, dir_rows[i].known, dir_rows[i].want);

    run_segment(SegMixed, 200);
    run_segment(SegRise, 0);
    // keep stepping against the top stop
    run_segment(SegRise, 30);
    sender_eager = 1'b1;
    hold_off_req = 1'b1;
    run_segment(SegMixed, 180);
    sender_eager = 1'b0;
    run_segment(SegFall, 0);
    run_segment(SegFall, 20);
    run_segment(SegMixed, 220);
    in_if.valid <= 1'b0;

    while (due_reports.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && due_reports.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
